[rtl/l2l4p_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2l4p_pkg: shared types and constants of the L2-L4 header parser
// Protocol constants, parse phases, status codes and the result record.
// ----------------------------------------------------------------------------
package l2l4p_pkg;

   localparam int OFS_W     = 17;   // width of offset and length result fields
   localparam int CNT_OUT_W = 32;   // visible width of the frame counters
   localparam int HB_W      = 7;    // header length in bytes, up to 60

   localparam logic [15:0] TPID_8021Q  = 16'h8100;
   localparam logic [15:0] TPID_8021AD = 16'h88A8;
   localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP   = 8'd6;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;

   // byte positions and lengths
   localparam int ETH_TYPE_LAST  = 13;
   localparam int ETH_HDR_BYTES  = 14;
   localparam int TAG_BYTES      = 4;
   localparam int MIN_HDR_BYTES  = 20;
   localparam int IPV6_HDR_BYTES = 40;
   localparam int UDP_HDR_BYTES  = 8;
   localparam int IP4_IHL_AT     = 0;
   localparam int IP4_PROTO_AT   = 9;
   localparam int IP6_NH_AT      = 6;
   localparam int TCP_DOFF_AT    = 12;

   typedef enum logic [2:0] {
      PH_ETH  = 3'd0,
      PH_TAG  = 3'd1,
      PH_IP4  = 3'd2,
      PH_IP6  = 3'd3,
      PH_TCP  = 3'd4,
      PH_UDP  = 3'd5,
      PH_PAY  = 3'd6,
      PH_DONE = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_TRUNC  = 3'd1,
      ST_BADLEN = 3'd2,
      ST_ETYPE  = 3'd3,
      ST_PROTO  = 3'd4,
      ST_EMPTY  = 3'd5
   } status_type;

   typedef struct packed {
      logic                 frame_ok;
      status_type           status;
      logic [15:0]          ether_type;
      logic                 is_ipv6;
      logic [7:0]           ip_protocol;
      logic [OFS_W-1:0]     l3_offset;
      logic [OFS_W-1:0]     l4_offset;
      logic [OFS_W-1:0]     payload_offset;
      logic [OFS_W-1:0]     payload_length;
      logic [CNT_OUT_W-1:0] frames_total;
      logic [CNT_OUT_W-1:0] frames_dropped;
   } result_type;

endpackage

[rtl/l2l4p_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2l4p_req_if: frame byte request channel
// One frame byte per request, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface l2l4p_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/l2l4p_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2l4p_rsp_if: parse result channel
// One request per frame carrying the header summary and frame counters.
// ----------------------------------------------------------------------------
interface l2l4p_rsp_if
   import l2l4p_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic                 frame_ok;
   logic [2:0]           status;
   logic [15:0]          ether_type;
   logic                 is_ipv6;
   logic [7:0]           ip_protocol;
   logic [OFS_W-1:0]     l3_offset;
   logic [OFS_W-1:0]     l4_offset;
   logic [OFS_W-1:0]     payload_offset;
   logic [OFS_W-1:0]     payload_length;
   logic [CNT_OUT_W-1:0] frames_total;
   logic [CNT_OUT_W-1:0] frames_dropped;

   modport source (output valid, input ready, output frame_ok, output status,
                   output ether_type, output is_ipv6, output ip_protocol,
                   output l3_offset, output l4_offset, output payload_offset,
                   output payload_length, output frames_total,
                   output frames_dropped);
   modport sink   (input valid, output ready, input frame_ok, input status,
                   input ether_type, input is_ipv6, input ip_protocol,
                   input l3_offset, input l4_offset, input payload_offset,
                   input payload_length, input frames_total,
                   input frames_dropped);
endinterface

[rtl/l2l4p_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2l4p_in_stage: input register
// Holds one frame byte; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module l2l4p_in_stage (
   input  logic          clock,
   input  logic          reset,
   l2l4p_req_if.sink     req_ch,
   input  logic          take,
   output logic          stg_valid,
   output logic [7:0]    stg_data,
   output logic          stg_last
);

   logic       vld_ff, vld_in;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       load;

   assign req_ch.ready = !vld_ff || take;
   assign load         = req_ch.valid && req_ch.ready;
   assign vld_in       = load ? 1'b1 : (take ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_ch.data_byte;
         last_ff <= req_ch.last_byte;
      end
   end

   assign stg_valid = vld_ff;
   assign stg_data  = data_ff;
   assign stg_last  = last_ff;

endmodule

[rtl/l2l4p_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2l4p_parser: per-byte header walker and frame counters
// Tracks the current header, captures fields and builds the frame result.
// ----------------------------------------------------------------------------
module l2l4p_parser
   import l2l4p_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 65536,
   parameter int COUNTER_BITS    = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output logic       res_valid,
   output result_type res
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

   logic [POS_W-1:0]        pos_ff, pos_in, pos_nx;
   phase_type               ph_ff, ph_in, ph_nx;
   logic [POS_W-1:0]        nhs_ff, nhs_in, nhs_nx;
   logic [15:0]             ts_ff, ts_in, ts_nx;
   logic [15:0]             et_ff, et_in, et_nx;
   logic [7:0]              cp_ff, cp_in, cp_nx;
   logic [HB_W-1:0]         hb_ff, hb_in, hb_nx;
   logic [POS_W-1:0]        l3_ff, l3_in, l3_nx;
   logic [POS_W-1:0]        l4_ff, l4_in, l4_nx;
   logic [POS_W-1:0]        po_ff, po_in, po_nx;
   status_type              fc_ff, fc_in, fc_nx;
   logic [COUNTER_BITS-1:0] tot_ff, tot_in, drop_ff, drop_in;

   logic                    active;
   logic [POS_W-1:0]        rel, pos_p1, pay_len;
   logic [POS_W:0]          rel_p1;
   logic [15:0]             ts_shift;
   phase_type               net_ph, tr_ph;
   logic                    hdr_end;
   status_type              st;
   logic                    l3_done;
   logic                    done;

   assign active   = pos_ff < POS_W'(MAX_FRAME_BYTES);
   assign rel      = pos_ff - nhs_ff;
   assign rel_p1   = {1'b0, rel} + 1'b1;
   assign pos_p1   = pos_ff + 1'b1;
   assign ts_shift = {ts_ff[7:0], data_byte};
   assign done     = step && last_byte;
   assign hdr_end  = (rel >= POS_W'(MIN_HDR_BYTES - 1)) && (rel_p1 == (POS_W + 1)'(hb_nx));

   // next phase once an ethertype is known
   always_comb begin
      if (ts_shift == TPID_8021Q || ts_shift == TPID_8021AD) begin
         net_ph = PH_TAG;
      end else if (ts_shift == ETYPE_IPV4) begin
         net_ph = PH_IP4;
      end else if (ts_shift == ETYPE_IPV6) begin
         net_ph = PH_IP6;
      end else begin
         net_ph = PH_DONE;
      end
   end

   // next phase once the network header is complete
   always_comb begin
      if (cp_ff == PROTO_TCP) begin
         tr_ph = PH_TCP;
      end else if (cp_ff == PROTO_UDP) begin
         tr_ph = PH_UDP;
      end else begin
         tr_ph = PH_DONE;
      end
   end

   always_comb begin
      pos_nx = pos_ff;
      ph_nx  = ph_ff;
      nhs_nx = nhs_ff;
      ts_nx  = ts_ff;
      et_nx  = et_ff;
      cp_nx  = cp_ff;
      hb_nx  = hb_ff;
      l3_nx  = l3_ff;
      l4_nx  = l4_ff;
      po_nx  = po_ff;
      fc_nx  = fc_ff;
      if (active) begin
         ts_nx  = ts_shift;
         pos_nx = pos_p1;
         case (ph_ff)
            PH_ETH: begin
               if (pos_ff == POS_W'(ETH_TYPE_LAST)) begin
                  et_nx  = ts_shift;
                  nhs_nx = POS_W'(ETH_HDR_BYTES);
                  ph_nx  = net_ph;
                  if (net_ph == PH_DONE) fc_nx = ST_ETYPE;
               end
            end
            PH_TAG: begin
               if (rel == POS_W'(TAG_BYTES - 1)) begin
                  et_nx  = ts_shift;
                  nhs_nx = pos_p1;
                  ph_nx  = net_ph;
                  if (net_ph == PH_DONE) fc_nx = ST_ETYPE;
               end
            end
            PH_IP4: begin
               if (rel == POS_W'(IP4_IHL_AT)) hb_nx = {1'b0, data_byte[3:0], 2'b00};
               if (rel == POS_W'(IP4_PROTO_AT)) cp_nx = data_byte;
               if (rel == POS_W'(MIN_HDR_BYTES - 1) && hb_nx < HB_W'(MIN_HDR_BYTES)) begin
                  ph_nx = PH_DONE;
                  fc_nx = ST_BADLEN;
               end else if (hdr_end) begin
                  l3_nx  = nhs_ff;
                  nhs_nx = pos_p1;
                  ph_nx  = tr_ph;
                  if (tr_ph == PH_DONE) fc_nx = ST_PROTO;
               end
            end
            PH_IP6: begin
               if (rel == POS_W'(IP6_NH_AT)) cp_nx = data_byte;
               if (rel == POS_W'(IPV6_HDR_BYTES - 1)) begin
                  l3_nx  = nhs_ff;
                  nhs_nx = pos_p1;
                  ph_nx  = tr_ph;
                  if (tr_ph == PH_DONE) fc_nx = ST_PROTO;
               end
            end
            PH_TCP: begin
               if (rel == POS_W'(TCP_DOFF_AT)) hb_nx = {1'b0, data_byte[7:4], 2'b00};
               if (rel == POS_W'(MIN_HDR_BYTES - 1) && hb_nx < HB_W'(MIN_HDR_BYTES)) begin
                  ph_nx = PH_DONE;
                  fc_nx = ST_BADLEN;
               end else if (hdr_end) begin
                  l4_nx = nhs_ff;
                  po_nx = pos_p1;
                  ph_nx = PH_PAY;
               end
            end
            PH_UDP: begin
               if (rel == POS_W'(UDP_HDR_BYTES - 1)) begin
                  l4_nx = nhs_ff;
                  po_nx = pos_p1;
                  ph_nx = PH_PAY;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // frame summary from the state after this byte
   assign pay_len = pos_nx - po_nx;
   assign l3_done = l3_nx != '0;

   always_comb begin
      case (ph_nx)
         PH_DONE: st = fc_nx;
         PH_TAG:  st = ST_ETYPE;
         PH_PAY:  st = (pay_len == '0) ? ST_EMPTY : ST_OK;
         default: st = ST_TRUNC;
      endcase
   end

   assign tot_in  = done ? tot_ff + 1'b1 : tot_ff;
   assign drop_in = (done && st != ST_OK) ? drop_ff + 1'b1 : drop_ff;

   always_comb begin
      res.frame_ok       = (st == ST_OK);
      res.status         = st;
      res.ether_type     = et_nx;
      res.is_ipv6        = l3_done && (et_nx == ETYPE_IPV6);
      res.ip_protocol    = l3_done ? cp_nx : 8'd0;
      res.l3_offset      = OFS_W'(l3_nx);
      res.l4_offset      = OFS_W'(l4_nx);
      res.payload_offset = (ph_nx == PH_PAY) ? OFS_W'(po_nx) : '0;
      res.payload_length = (ph_nx == PH_PAY) ? OFS_W'(pay_len) : '0;
      res.frames_total   = CNT_OUT_W'(tot_in);
      res.frames_dropped = CNT_OUT_W'(drop_in);
   end
   assign res_valid = done;

   // state: hold, advance by one byte, or clear at end of frame
   always_comb begin
      pos_in = pos_ff;
      ph_in  = ph_ff;
      nhs_in = nhs_ff;
      ts_in  = ts_ff;
      et_in  = et_ff;
      cp_in  = cp_ff;
      hb_in  = hb_ff;
      l3_in  = l3_ff;
      l4_in  = l4_ff;
      po_in  = po_ff;
      fc_in  = fc_ff;
      if (done) begin
         pos_in = '0;
         ph_in  = PH_ETH;
         nhs_in = '0;
         ts_in  = '0;
         et_in  = '0;
         cp_in  = '0;
         hb_in  = '0;
         l3_in  = '0;
         l4_in  = '0;
         po_in  = '0;
         fc_in  = ST_OK;
      end else if (step) begin
         pos_in = pos_nx;
         ph_in  = ph_nx;
         nhs_in = nhs_nx;
         ts_in  = ts_nx;
         et_in  = et_nx;
         cp_in  = cp_nx;
         hb_in  = hb_nx;
         l3_in  = l3_nx;
         l4_in  = l4_nx;
         po_in  = po_nx;
         fc_in  = fc_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ph_ff   <= PH_ETH;
         nhs_ff  <= '0;
         ts_ff   <= '0;
         et_ff   <= '0;
         cp_ff   <= '0;
         hb_ff   <= '0;
         l3_ff   <= '0;
         l4_ff   <= '0;
         po_ff   <= '0;
         fc_ff   <= ST_OK;
         tot_ff  <= '0;
         drop_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         ph_ff   <= ph_in;
         nhs_ff  <= nhs_in;
         ts_ff   <= ts_in;
         et_ff   <= et_in;
         cp_ff   <= cp_in;
         hb_ff   <= hb_in;
         l3_ff   <= l3_in;
         l4_ff   <= l4_in;
         po_ff   <= po_in;
         fc_ff   <= fc_in;
         tot_ff  <= tot_in;
         drop_ff <= drop_in;
      end
   end

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      done |=> (ph_ff == PH_ETH && pos_ff == '0 && l3_ff == '0))
      else $error("parser state not cleared after frame end");

   a_total_counts: assert property (@(posedge clock) disable iff (reset)
      done |=> (tot_ff == $past(tot_ff) + 1'b1))
      else $error("frame total did not advance");

   a_drop_counts: assert property (@(posedge clock) disable iff (reset)
      done |=> (drop_ff == $past(drop_ff) + COUNTER_BITS'($past(st != ST_OK))))
      else $error("drop count out of step with status");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_FRAME_BYTES) && nhs_ff <= pos_ff)
      else $error("byte position out of range");

endmodule

[rtl/l2l4_header_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2_l4_header_parser_top: Ethernet/VLAN/IPv4/IPv6/TCP/UDP header parser
//
//   channel  dir  handshake      per request
//   req_ch   in   valid/ready    one frame byte, last_byte on the final one
//   rsp_ch   out  valid/ready    one header summary per frame
//
// Takes one frame byte per clock while the output register is free or being
// emptied; the parse state is updated from the input register, and the frame
// result lands in an output register when the parser takes the final byte.
// Synchronous active-high reset clears the parse state and both counters.
// A stalled result holds; bytes keep flowing until the input register is
// also full, i.e. one byte plus one result of slack.
// ----------------------------------------------------------------------------
module l2_l4_header_parser_top
   import l2l4p_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 65536,
   parameter int COUNTER_BITS    = 32
) (
   input  logic          clock,
   input  logic          reset,
   l2l4p_req_if.sink     req_ch,
   l2l4p_rsp_if.source   rsp_ch
);

   logic       stg_valid;
   logic [7:0] stg_data;
   logic       stg_last;
   logic       advance;     // output register free or being emptied
   logic       step;        // parser consumes the staged byte this cycle
   logic       res_valid;
   result_type res;

   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_ff;

   assign advance = !rsp_vld_ff || rsp_ch.ready;
   assign step    = stg_valid && advance;

   // input register: one staged byte
   l2l4p_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .take      (advance),
      .stg_valid (stg_valid),
      .stg_data  (stg_data),
      .stg_last  (stg_last)
   );

   // header walker, field capture and counters
   l2l4p_parser #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .COUNTER_BITS    (COUNTER_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (stg_data),
      .last_byte (stg_last),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register: loads whenever the previous result is gone or leaving
   assign rsp_vld_in = advance ? res_valid : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.frame_ok       = rsp_ff.frame_ok;
   assign rsp_ch.status         = rsp_ff.status;
   assign rsp_ch.ether_type     = rsp_ff.ether_type;
   assign rsp_ch.is_ipv6        = rsp_ff.is_ipv6;
   assign rsp_ch.ip_protocol    = rsp_ff.ip_protocol;
   assign rsp_ch.l3_offset      = rsp_ff.l3_offset;
   assign rsp_ch.l4_offset      = rsp_ff.l4_offset;
   assign rsp_ch.payload_offset = rsp_ff.payload_offset;
   assign rsp_ch.payload_length = rsp_ff.payload_length;
   assign rsp_ch.frames_total   = rsp_ff.frames_total;
   assign rsp_ch.frames_dropped = rsp_ff.frames_dropped;

   a_ok_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.frame_ok == (rsp_ff.status == ST_OK)))
      else $error("frame_ok disagrees with status");

   a_payload_only_parsed: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.status != ST_OK && rsp_ff.status != ST_EMPTY)
         |-> (rsp_ff.payload_offset == '0 && rsp_ff.payload_length == '0))
      else $error("payload reported for a failed frame");

   a_layer_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.l4_offset != '0)
         |-> (rsp_ff.l3_offset != '0 && rsp_ff.l4_offset > rsp_ff.l3_offset))
      else $error("transport header before network header");

endmodule
